[hw/rtl/aapd_pkg.sv]
// ----------------------------------------------------------------------------
// aapd_pkg
// Shared types, constants and the arctangent table for the averaged
// accelerometer pitch unit.
// ----------------------------------------------------------------------------
package aapd_pkg;

    // Field widths
    localparam int ACC_W   = 16;
    localparam int PITCH_W = 9;

    // Signed average after division, one bit of headroom for -32768
    localparam int AVG_W    = 17;
    // CORDIC vector width: 2^31 input scale plus gain and sqrt(2) growth
    localparam int CORDIC_W = 35;
    // Angle accumulator in Q16 radians, magnitude stays below 2^19
    localparam int ANG_W    = 21;
    // Fractional bits of the CORDIC input scale
    localparam int FRAC_W   = 16;

    localparam int ATAN_W   = 17;
    localparam int ATAN_IDX_W = 5;
    localparam int PI_Q16   = 205887;

    // Degree conversion: deg = |ang| * 5729 / (65536 * 100)
    localparam int DEG_MUL_W = 13;
    localparam int DEG_MUL   = 5729;
    localparam int DEG_DIV   = 100;
    localparam int PROD_W    = ANG_W - 1 + DEG_MUL_W;
    // Integer part of the scaled angle, the input of the divide by 100
    localparam int DEG_IN_W  = 16;
    localparam int DEG_MAX   = 180;
    localparam int DEG_MAG_W = 8;

    // Controller to datapath commands
    typedef struct packed {
        logic acc;          // add the accepted item into the sums
        logic avg;          // divide the sums into averages, clear sums
        logic avg_load;     // form averages, pre-rotate, load CORDIC
        logic cordic_step;  // run one CORDIC iteration
        logic mul;          // scale the angle magnitude
        logic deg_div;      // divide the scaled angle by 100
        logic out_load;     // load the result register
    } aapd_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic avg_zero;     // both averages are zero
    } aapd_sts_t;

    // atan(2^-i) in Q16, rounded to nearest; zero past the table
    function automatic logic [ATAN_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] val;
        unique case (idx)
            5'd0:    val = 17'd51472;
            5'd1:    val = 17'd30386;
            5'd2:    val = 17'd16055;
            5'd3:    val = 17'd8150;
            5'd4:    val = 17'd4091;
            5'd5:    val = 17'd2047;
            5'd6:    val = 17'd1024;
            5'd7:    val = 17'd512;
            5'd8:    val = 17'd256;
            5'd9:    val = 17'd128;
            5'd10:   val = 17'd64;
            5'd11:   val = 17'd32;
            5'd12:   val = 17'd16;
            5'd13:   val = 17'd8;
            5'd14:   val = 17'd4;
            5'd15:   val = 17'd2;
            5'd16:   val = 17'd1;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

[hw/rtl/aapd_div.sv]
// ----------------------------------------------------------------------------
// aapd_div
// Unsigned truncating division by a constant through reciprocal
// multiplication, quotient registered on load.
// ----------------------------------------------------------------------------
module aapd_div #(
    parameter int DVD_W   = 19,
    parameter int DIVISOR = 5
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  logic [DVD_W-1:0] dividend,
    output logic [DVD_W-1:0] quotient
);

    // Reciprocal scaled by 2^SHIFT and rounded up; exact for every DVD_W-bit dividend
    localparam int     SHIFT = DVD_W + $clog2(DIVISOR);
    localparam int     PRD_W = SHIFT + DVD_W;
    localparam longint RECIP = ((longint'(1) << SHIFT) + longint'(DIVISOR) - 1)
                               / longint'(DIVISOR);

    logic [PRD_W-1:0] prod;
    logic [DVD_W-1:0] quo_reg;

    assign prod = PRD_W'(dividend) * PRD_W'(RECIP);

    // Hold the quotient until the next load
    always_ff @(posedge aclk) begin
        if (load) begin
            quo_reg <= prod[SHIFT +: DVD_W];
        end
    end

    assign quotient = quo_reg;

    // Each quotient is the truncated division of the dividend loaded before it
    assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> ((PRD_W'(quo_reg) * PRD_W'(DIVISOR) <= PRD_W'($past(dividend)))
              && (PRD_W'($past(dividend))
                  < PRD_W'(quo_reg) * PRD_W'(DIVISOR) + PRD_W'(DIVISOR))))
        else $error("division by constant is not exact");

endmodule

[hw/rtl/aapd_dp.sv]
// ----------------------------------------------------------------------------
// aapd_dp
// Datapath: running sums, averaging dividers, CORDIC vectoring unit,
// degree scaling and the result register.
// ----------------------------------------------------------------------------
module aapd_dp
    import aapd_pkg::*;
#(
    parameter int SAMPLES      = 5,
    parameter int ITW          = 4
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  aapd_cmd_t                 cmd,
    input  logic [ITW-1:0]            cordic_idx,
    output aapd_sts_t                 sts,
    input  logic signed [ACC_W-1:0]   s_acc_x,
    input  logic signed [ACC_W-1:0]   s_acc_z,
    output logic signed [PITCH_W-1:0] m_pitch_degrees
);

    localparam int SUM_W = ACC_W + $clog2(SAMPLES);

    logic signed [SUM_W-1:0]    sum_x_reg, sum_z_reg;
    logic                       sx_neg_reg, sz_neg_reg;
    logic signed [CORDIC_W-1:0] p_reg, q_reg;
    logic signed [ANG_W-1:0]    ang_reg;
    logic                       ang_neg_reg;
    logic [PROD_W-1:0]          prod_reg;
    logic signed [PITCH_W-1:0]  pitch_reg;

    logic [SUM_W-1:0]           mag_x, mag_z;
    logic [SUM_W-1:0]           quo_x, quo_z;
    logic [DEG_IN_W-1:0]        quo_deg;

    logic signed [AVG_W-1:0]    avg_x, avg_z;
    logic signed [CORDIC_W-1:0] p_init, q_init;
    logic signed [CORDIC_W-1:0] dp_shift, dq_shift;
    logic signed [ANG_W-1:0]    a_step;
    logic [ANG_W-2:0]           ang_mag;
    logic [DEG_MAG_W-1:0]       deg_mag;

    // Accumulate the group, clear once the dividers have taken the sums
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_x_reg <= '0;
            sum_z_reg <= '0;
        end else if (cmd.acc) begin
            sum_x_reg <= sum_x_reg + SUM_W'(s_acc_x);
            sum_z_reg <= sum_z_reg + SUM_W'(s_acc_z);
        end else if (cmd.avg) begin
            sum_x_reg <= '0;
            sum_z_reg <= '0;
        end
    end

    // Magnitudes for truncating division
    assign mag_x = sum_x_reg[SUM_W-1] ? SUM_W'(-sum_x_reg) : SUM_W'(sum_x_reg);
    assign mag_z = sum_z_reg[SUM_W-1] ? SUM_W'(-sum_z_reg) : SUM_W'(sum_z_reg);

    aapd_div #(
        .DVD_W   (SUM_W),
        .DIVISOR (SAMPLES)
    ) u_div_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (cmd.avg),
        .dividend (mag_x),
        .quotient (quo_x)
    );

    aapd_div #(
        .DVD_W   (SUM_W),
        .DIVISOR (SAMPLES)
    ) u_div_z (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (cmd.avg),
        .dividend (mag_z),
        .quotient (quo_z)
    );

    // Divide the integer part of the scaled angle by 100
    aapd_div #(
        .DVD_W   (DEG_IN_W),
        .DIVISOR (DEG_DIV)
    ) u_div_deg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (cmd.deg_div),
        .dividend (prod_reg[FRAC_W +: DEG_IN_W]),
        .quotient (quo_deg)
    );

    assign sts.avg_zero = (quo_x == '0) && (quo_z == '0);

    // Signed averages and the pre-rotated CORDIC start vector
    assign avg_x  = sx_neg_reg ? -$signed({1'b0, quo_x[ACC_W-1:0]})
                               :  $signed({1'b0, quo_x[ACC_W-1:0]});
    assign avg_z  = sz_neg_reg ? -$signed({1'b0, quo_z[ACC_W-1:0]})
                               :  $signed({1'b0, quo_z[ACC_W-1:0]});
    assign p_init = CORDIC_W'(avg_z) <<< FRAC_W;
    assign q_init = CORDIC_W'(avg_x) <<< FRAC_W;

    // One vectoring iteration
    assign dp_shift = q_reg >>> cordic_idx;
    assign dq_shift = p_reg >>> cordic_idx;
    assign a_step   = $signed(ANG_W'(atan_q16(ATAN_IDX_W'(cordic_idx))));

    assign ang_mag  = ang_reg[ANG_W-1] ? (ANG_W-1)'(-ang_reg) : ang_reg[ANG_W-2:0];

    // Clamp the degree magnitude, never taken at these constants
    assign deg_mag  = (quo_deg > DEG_IN_W'(DEG_MAX)) ? DEG_MAG_W'(DEG_MAX)
                                                     : quo_deg[DEG_MAG_W-1:0];

    always_ff @(posedge aclk) begin
        // Hold the sum signs for the averaging pass
        if (cmd.avg) begin
            sx_neg_reg <= sum_x_reg[SUM_W-1];
            sz_neg_reg <= sum_z_reg[SUM_W-1];
        end
        // Load the vector, rotating into the right half plane
        if (cmd.avg_load) begin
            if (sts.avg_zero) begin
                p_reg   <= '0;
                q_reg   <= '0;
                ang_reg <= '0;
            end else if (avg_z < 0) begin
                p_reg   <= -p_init;
                q_reg   <= -q_init;
                ang_reg <= (avg_x >= 0) ? ANG_W'(PI_Q16) : -ANG_W'(PI_Q16);
            end else begin
                p_reg   <= p_init;
                q_reg   <= q_init;
                ang_reg <= '0;
            end
        end else if (cmd.cordic_step) begin
            if (q_reg > 0) begin
                p_reg   <= p_reg + dp_shift;
                q_reg   <= q_reg - dq_shift;
                ang_reg <= ang_reg + a_step;
            end else begin
                p_reg   <= p_reg - dp_shift;
                q_reg   <= q_reg + dq_shift;
                ang_reg <= ang_reg - a_step;
            end
        end
        // Scale the angle magnitude toward degrees
        if (cmd.mul) begin
            prod_reg    <= PROD_W'(ang_mag) * PROD_W'(DEG_MUL);
            ang_neg_reg <= ang_reg[ANG_W-1];
        end
        // Restore the sign of the truncated degree value
        if (cmd.out_load) begin
            pitch_reg <= ang_neg_reg ? -$signed({1'b0, deg_mag})
                                     :  $signed({1'b0, deg_mag});
        end
    end

    assign m_pitch_degrees = pitch_reg;

endmodule

[hw/rtl/aapd_ctrl.sv]
// ----------------------------------------------------------------------------
// aapd_ctrl
// Controller: counts items of a group and sequences averaging, CORDIC,
// degree scaling and result handoff.
// ----------------------------------------------------------------------------
module aapd_ctrl
    import aapd_pkg::*;
#(
    parameter int SAMPLES      = 5,
    parameter int CORDIC_ITERS = 16,
    parameter int ITW          = 4
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    output aapd_cmd_t      cmd,
    output logic [ITW-1:0] cordic_idx,
    input  aapd_sts_t      sts
);

    localparam int CNT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;

    typedef enum logic [2:0] {
        ST_ACC,
        ST_AVG,
        ST_LOAD,
        ST_CORDIC,
        ST_MUL,
        ST_DEG,
        ST_OUT
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [ITW-1:0]   iter_reg, iter_next;
    logic             m_valid_reg, m_valid_next;
    logic             last_item;

    assign last_item = (cnt_reg == CNT_W'(SAMPLES - 1));

    // Decode commands from the current state
    always_comb begin
        cmd             = '0;
        cmd.acc         = (state_reg == ST_ACC) && s_valid;
        cmd.avg         = (state_reg == ST_AVG);
        cmd.avg_load    = (state_reg == ST_LOAD);
        cmd.cordic_step = (state_reg == ST_CORDIC);
        cmd.mul         = (state_reg == ST_MUL);
        cmd.deg_div     = (state_reg == ST_DEG);
        cmd.out_load    = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);
    end

    // Next state, group count, iteration count and result valid
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        iter_next    = iter_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_ACC: begin
                if (s_valid) begin
                    if (last_item) begin
                        cnt_next   = '0;
                        state_next = ST_AVG;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            ST_AVG: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                iter_next  = '0;
                state_next = sts.avg_zero ? ST_MUL : ST_CORDIC;
            end
            ST_CORDIC: begin
                if (iter_reg == ITW'(CORDIC_ITERS - 1)) begin
                    state_next = ST_MUL;
                end else begin
                    iter_next = iter_reg + 1'b1;
                end
            end
            ST_MUL: begin
                state_next = ST_DEG;
            end
            ST_DEG: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_ACC;
                end
            end
            default: begin
                state_next = ST_ACC;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_ACC;
            cnt_reg     <= '0;
            iter_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            iter_reg    <= iter_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready    = (state_reg == ST_ACC);
    assign m_valid    = m_valid_reg;
    assign cordic_idx = iter_reg;

    // The last item of a group starts the averaging pass
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && last_item) |=> (state_reg == ST_AVG))
        else $error("group completion did not start averaging");

    // Never overwrite a result that is still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result overwritten while pending");

    // CORDIC index stays inside the configured iteration count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CORDIC) |-> (iter_reg <= ITW'(CORDIC_ITERS - 1)))
        else $error("CORDIC index out of range");

    // Group count rests at zero while a group is being processed
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_ACC) |-> (cnt_reg == '0))
        else $error("group count moved outside accumulation");

endmodule

[hw/rtl/averaged_accel_pitch_degrees_unit.sv]
// ----------------------------------------------------------------------------
// averaged_accel_pitch_degrees_unit
// Averages groups of accelerometer X/Z samples and reports the pitch angle
// atan2(avg_x, avg_z) in whole degrees.
// ----------------------------------------------------------------------------
// Items are taken one per cycle until a group of SAMPLES is complete; the
// last item of a group then starts a computation (averaging, CORDIC load,
// CORDIC_ITERS iterations, scaling, division by 100 and result load, with
// the iterations skipped when both averages are zero), during which s_ready
// is low. The CORDIC vectoring unit takes one iteration per cycle; the
// divisions by SAMPLES and by 100 are registered reciprocal multiplications.
// A finished result sits in the output register while the next group is
// collected; a group only waits at its end if the previous result has not
// been taken. Averages truncate toward zero, atan2(0,0) gives 0, and the
// angle is truncated toward zero to whole degrees in -180..180.
// ----------------------------------------------------------------------------
module averaged_accel_pitch_degrees_unit
    import aapd_pkg::*;
#(
    parameter int SAMPLES      = 5,
    parameter int CORDIC_ITERS = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [ACC_W-1:0]   s_acc_x,
    input  logic signed [ACC_W-1:0]   s_acc_z,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [PITCH_W-1:0] m_pitch_degrees
);

    localparam int ITW = $clog2(CORDIC_ITERS);

    aapd_cmd_t      cmd;
    aapd_sts_t      sts;
    logic [ITW-1:0] cordic_idx;

    aapd_ctrl #(
        .SAMPLES      (SAMPLES),
        .CORDIC_ITERS (CORDIC_ITERS),
        .ITW          (ITW)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .cmd        (cmd),
        .cordic_idx (cordic_idx),
        .sts        (sts)
    );

    aapd_dp #(
        .SAMPLES      (SAMPLES),
        .ITW          (ITW)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .cordic_idx      (cordic_idx),
        .sts             (sts),
        .s_acc_x         (s_acc_x),
        .s_acc_z         (s_acc_z),
        .m_pitch_degrees (m_pitch_degrees)
    );

endmodule
